>>> rtl/ipd_pkg.sv
// Package for the IP packet delineator: word types, parse modes, status codes
// and register defaults. No dependencies; every other file of the block uses it.
`default_nettype none

package ipd_pkg;

	// Field widths fixed by the stream format.
	localparam int BYTE_W     = 8;
	localparam int CHUNK_W    = 16;
	localparam int LHL_W      = 6;
	localparam int PLEN_W     = 12;
	localparam int STATUS_W   = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 12;

	// Register defaults and the default length cap.
	localparam int LENGTH_CAP_DEF = 2500;
	localparam logic [LHL_W-1:0]  LINK_HDR_LEN_RST = 6'd14;
	localparam logic [PLEN_W-1:0] MAX_PKT_LEN_RST  = 12'd1500;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_LINK_HDR_LEN = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_MAX_PKT_LEN  = 1'b1;

	// End status codes.
	localparam logic [STATUS_W-1:0] END_GOOD     = 2'd0;
	localparam logic [STATUS_W-1:0] END_OVERSIZE = 2'd1;
	localparam logic [STATUS_W-1:0] END_ABORT    = 2'd2;

	// Version nibbles.
	localparam logic [3:0] VER_IPV4 = 4'h4;
	localparam logic [3:0] VER_IPV6 = 4'h6;

	// Header sizes and the byte position of the low length byte.
	localparam logic [PLEN_W-1:0] HDR_LEN_V4 = 12'd20;
	localparam logic [PLEN_W-1:0] HDR_LEN_V6 = 12'd40;
	localparam logic [PLEN_W-1:0] LEN_LO_V4  = 12'd3;
	localparam logic [PLEN_W-1:0] LEN_LO_V6  = 12'd5;
	localparam logic [CHUNK_W-1:0] MIN_START_LEFT = 16'd6;

	typedef enum logic [1:0] {
		MODE_IDLE,
		MODE_PACKET,
		MODE_DISCARD
	} parse_mode_t;

	typedef struct packed {
		logic [LHL_W-1:0]  link_header_len;
		logic [PLEN_W-1:0] max_packet_len;
	} cfg_t;

	typedef struct packed {
		logic [BYTE_W-1:0]  data_byte;
		logic               chunk_first;
		logic [CHUNK_W-1:0] chunk_len;
	} in_word_t;

	typedef struct packed {
		logic [BYTE_W-1:0]   out_byte;
		logic                in_packet;
		logic                packet_start;
		logic                packet_end;
		logic [STATUS_W-1:0] end_status;
		logic                ip_version;
	} out_word_t;

endpackage

`default_nettype wire

>>> rtl/ipd_if.sv
// Stream interfaces of the IP packet delineator: chunk bytes in, tagged bytes out.
// Depends on ipd_pkg for the field widths.
`default_nettype none

interface ipd_in_if;
	logic                         valid;
	logic                         ready;
	logic [ipd_pkg::BYTE_W-1:0]   data_byte;
	logic                         chunk_first;
	logic [ipd_pkg::CHUNK_W-1:0]  chunk_len;

	modport source (output valid, data_byte, chunk_first, chunk_len, input ready);
	modport sink   (input valid, data_byte, chunk_first, chunk_len, output ready);
endinterface

interface ipd_out_if;
	logic                          valid;
	logic                          ready;
	logic [ipd_pkg::BYTE_W-1:0]    out_byte;
	logic                          in_packet;
	logic                          packet_start;
	logic                          packet_end;
	logic [ipd_pkg::STATUS_W-1:0]  end_status;
	logic                          ip_version;

	modport source (output valid, out_byte, in_packet, packet_start, packet_end,
		end_status, ip_version, input ready);
	modport sink   (input valid, out_byte, in_packet, packet_start, packet_end,
		end_status, ip_version, output ready);
	modport mon    (input valid, ready, out_byte, in_packet, packet_start, packet_end,
		end_status, ip_version);
endinterface

`default_nettype wire

>>> rtl/ipd_parser.sv
// Per-byte parse state of the IP packet delineator and the role of each byte.
// Depends on ipd_pkg; instantiated by ip_packet_delineator_top.
`default_nettype none

module ipd_parser #(
	parameter int LENGTH_CAP = ipd_pkg::LENGTH_CAP_DEF
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                step,
	input  ipd_pkg::in_word_t  in_word,
	input  ipd_pkg::cfg_t      cfg,
	output ipd_pkg::out_word_t res
);

	localparam logic [ipd_pkg::PLEN_W-1:0] CapLen = ipd_pkg::PLEN_W'(LENGTH_CAP);

	// Parse state.
	ipd_pkg::parse_mode_t                mode_q, mode_n;
	logic [ipd_pkg::CHUNK_W-1:0]         chunk_left_q, chunk_left_n;
	logic [ipd_pkg::LHL_W-1:0]           skip_left_q, skip_left_n;
	logic [ipd_pkg::PLEN_W-1:0]          packet_count_q, packet_count_n;
	logic [ipd_pkg::PLEN_W-1:0]          packet_length_q, packet_length_n;
	logic [ipd_pkg::BYTE_W-1:0]          length_high_byte_q, length_high_byte_n;
	logic                                version_is_six_q, version_is_six_n;
	logic                                oversize_mark_q, oversize_mark_n;

	// Chunk view after a possible restart on chunk_first.
	ipd_pkg::parse_mode_t                mode_c;
	logic [ipd_pkg::CHUNK_W-1:0]         chunk_left_c;
	logic [ipd_pkg::LHL_W-1:0]           skip_left_c;

	// Length field arithmetic.
	logic [ipd_pkg::CHUNK_W:0]           raw_len;
	logic [ipd_pkg::PLEN_W-1:0]          capped_len;
	logic [ipd_pkg::PLEN_W-1:0]          hdr_len;
	logic [ipd_pkg::PLEN_W-1:0]          lo_idx;
	logic [3:0]                          ver_nib;
	logic                                aborted;

	assign ver_nib = in_word.data_byte[7:4];
	assign hdr_len = version_is_six_q ? ipd_pkg::HDR_LEN_V6 : ipd_pkg::HDR_LEN_V4;
	assign lo_idx  = version_is_six_q ? ipd_pkg::LEN_LO_V6 : ipd_pkg::LEN_LO_V4;

	// Packet length from the header, plus the fixed header for IPv6, capped.
	always_comb begin
		raw_len = {1'b0, length_high_byte_q, in_word.data_byte} +
			(version_is_six_q ? (ipd_pkg::CHUNK_W+1)'(ipd_pkg::HDR_LEN_V6) : '0);
		if (raw_len > (ipd_pkg::CHUNK_W+1)'(CapLen)) begin
			capped_len = CapLen;
		end else begin
			capped_len = raw_len[ipd_pkg::PLEN_W-1:0];
		end
	end

	// Next state and the role of the current byte.
	always_comb begin
		mode_c       = (in_word.chunk_first && mode_q != ipd_pkg::MODE_PACKET) ?
			ipd_pkg::MODE_IDLE : mode_q;
		chunk_left_c = in_word.chunk_first ? in_word.chunk_len : chunk_left_q;
		skip_left_c  = in_word.chunk_first ? cfg.link_header_len : skip_left_q;

		mode_n             = mode_c;
		chunk_left_n       = chunk_left_c;
		skip_left_n        = skip_left_c;
		packet_count_n     = packet_count_q;
		packet_length_n    = packet_length_q;
		length_high_byte_n = length_high_byte_q;
		version_is_six_n   = version_is_six_q;
		oversize_mark_n    = oversize_mark_q;
		aborted            = 1'b0;

		res              = '0;
		res.out_byte     = in_word.data_byte;

		if (chunk_left_c != '0) begin
			chunk_left_n = chunk_left_c - 1'b1;
			if (skip_left_c != '0) begin
				skip_left_n = skip_left_c - 1'b1;
			end else begin
				unique case (mode_c)
					ipd_pkg::MODE_PACKET: begin
						packet_count_n = packet_count_q + 1'b1;
						if (packet_length_q == '0) begin
							if (packet_count_q == lo_idx - 1'b1) begin
								length_high_byte_n = in_word.data_byte;
							end else if (packet_count_q == lo_idx) begin
								if (capped_len <= hdr_len) begin
									aborted = 1'b1;
								end else begin
									packet_length_n = capped_len;
									oversize_mark_n = capped_len > cfg.max_packet_len;
								end
							end
						end
						res.in_packet  = 1'b1;
						res.ip_version = version_is_six_q;
						if (aborted) begin
							mode_n          = ipd_pkg::MODE_DISCARD;
							packet_length_n = packet_length_q;
							res.packet_end  = 1'b1;
							res.end_status  = ipd_pkg::END_ABORT;
						end else if (packet_length_n != '0 &&
							packet_count_n == packet_length_n) begin
							mode_n         = ipd_pkg::MODE_IDLE;
							res.packet_end = 1'b1;
							res.end_status = oversize_mark_n ? ipd_pkg::END_OVERSIZE :
								ipd_pkg::END_GOOD;
						end
					end
					ipd_pkg::MODE_IDLE: begin
						// A packet starts only on a good version nibble with room
						// left in the chunk for its length field.
						if ((ver_nib != ipd_pkg::VER_IPV4 && ver_nib != ipd_pkg::VER_IPV6)
							|| chunk_left_c < ipd_pkg::MIN_START_LEFT) begin
							mode_n = ipd_pkg::MODE_DISCARD;
						end else begin
							mode_n             = ipd_pkg::MODE_PACKET;
							version_is_six_n   = (ver_nib == ipd_pkg::VER_IPV6);
							packet_count_n     = ipd_pkg::PLEN_W'(1);
							packet_length_n    = '0;
							length_high_byte_n = '0;
							oversize_mark_n    = 1'b0;
							res.in_packet      = 1'b1;
							res.packet_start   = 1'b1;
							res.ip_version     = (ver_nib == ipd_pkg::VER_IPV6);
						end
					end
					default: begin
						mode_n = mode_c;
					end
				endcase
			end
		end
	end

	// State registers advance once per accepted byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q             <= ipd_pkg::MODE_IDLE;
			chunk_left_q       <= '0;
			skip_left_q        <= '0;
			packet_count_q     <= '0;
			packet_length_q    <= '0;
			length_high_byte_q <= '0;
			version_is_six_q   <= 1'b0;
			oversize_mark_q    <= 1'b0;
		end else if (step) begin
			mode_q             <= mode_n;
			chunk_left_q       <= chunk_left_n;
			skip_left_q        <= skip_left_n;
			packet_count_q     <= packet_count_n;
			packet_length_q    <= packet_length_n;
			length_high_byte_q <= length_high_byte_n;
			version_is_six_q   <= version_is_six_n;
			oversize_mark_q    <= oversize_mark_n;
		end
	end

endmodule

`default_nettype wire

>>> rtl/ip_packet_delineator_top.sv
// Top level of the IP packet delineator: configuration registers, input handshake
// and the result register. Depends on ipd_pkg, ipd_if.sv and ipd_parser.
//
// The delineator takes one chunk byte per cycle and returns each byte in the next
// cycle with its packet role (in packet, start, end, end status, IP version).
// Throughput is one byte per clock: the parse state updates once per byte,
// and the result register accepts a new byte in the same cycle its
// current word is taken, so in_ch.ready only drops while a result waits on a
// stalled out_ch. The user must write link_header_len and max_packet_len through
// cfg_we/cfg_index/cfg_wdata only while the stream is idle, which the block itself
// does not enforce. The one-bit cfg_index can name only these two registers.
// LENGTH_CAP caps the packet length and must fit in 12 bits.
`default_nettype none

module ip_packet_delineator_top #(
	parameter int LENGTH_CAP = ipd_pkg::LENGTH_CAP_DEF
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                cfg_we,
	input  wire [ipd_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  wire [ipd_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	ipd_in_if.sink                             in_ch,
	ipd_out_if.source                          out_ch
);

	ipd_pkg::cfg_t      cfg_q;
	ipd_pkg::in_word_t  in_word;
	ipd_pkg::out_word_t res;
	ipd_pkg::out_word_t res_q;
	logic               out_valid_q;
	logic               step;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.link_header_len <= ipd_pkg::LINK_HDR_LEN_RST;
			cfg_q.max_packet_len  <= ipd_pkg::MAX_PKT_LEN_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ipd_pkg::CFG_LINK_HDR_LEN: cfg_q.link_header_len <= cfg_wdata[ipd_pkg::LHL_W-1:0];
				ipd_pkg::CFG_MAX_PKT_LEN:  cfg_q.max_packet_len  <= cfg_wdata[ipd_pkg::PLEN_W-1:0];
				default: ;
			endcase
		end
	end

	// A byte is taken whenever the result register is empty or being emptied.
	assign in_ch.ready = !out_valid_q || out_ch.ready;
	assign step        = in_ch.valid && in_ch.ready;

	assign in_word.data_byte   = in_ch.data_byte;
	assign in_word.chunk_first = in_ch.chunk_first;
	assign in_word.chunk_len   = in_ch.chunk_len;

	ipd_parser #(
		.LENGTH_CAP (LENGTH_CAP)
	) u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.step    (step),
		.in_word (in_word),
		.cfg     (cfg_q),
		.res     (res)
	);

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (in_ch.ready) begin
			out_valid_q <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			res_q <= res;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.out_byte     = res_q.out_byte;
	assign out_ch.in_packet    = res_q.in_packet;
	assign out_ch.packet_start = res_q.packet_start;
	assign out_ch.packet_end   = res_q.packet_end;
	assign out_ch.end_status   = res_q.end_status;
	assign out_ch.ip_version   = res_q.ip_version;

endmodule

`default_nettype wire

>>> rtl/ipd_checker.sv
// Port-level checks on the result stream of the IP packet delineator, and the
// bind that attaches them to ip_packet_delineator_top. Depends on ipd_pkg, ipd_if.sv.
`default_nettype none

module ipd_checker (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          out_valid,
	input  wire                          out_ready,
	input  wire                          in_packet,
	input  wire                          packet_start,
	input  wire                          packet_end,
	input  wire [ipd_pkg::STATUS_W-1:0]  end_status,
	input  wire                          ip_version
);

	// A packet start or end marks a byte inside a packet.
	a_start_in_packet: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (packet_start || packet_end) |-> in_packet)
		else $error("packet start or end outside a packet");

	// A non-good status only appears on an end byte.
	a_status_on_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && end_status != ipd_pkg::END_GOOD |-> packet_end)
		else $error("end status set without packet end");

	// Status codes above abort are never produced.
	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (end_status == ipd_pkg::END_GOOD ||
			end_status == ipd_pkg::END_OVERSIZE ||
			end_status == ipd_pkg::END_ABORT))
		else $error("undefined end status");

	// Bytes outside packets carry no version.
	a_version_outside: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !in_packet |-> !ip_version)
		else $error("version set outside a packet");

	// A stalled result word stays offered.
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped while stalled");

endmodule

bind ip_packet_delineator_top ipd_checker u_ipd_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.in_packet    (out_ch.in_packet),
	.packet_start (out_ch.packet_start),
	.packet_end   (out_ch.packet_end),
	.end_status   (out_ch.end_status),
	.ip_version   (out_ch.ip_version)
);

`default_nettype wire
